>>> src/fqd_pkg.sv
// Shared types and constants for the handle queue with delete.
`default_nettype none

package fqd_pkg;

   localparam logic [1:0] ACT_ENQUEUE = 2'd0;
   localparam logic [1:0] ACT_DEQUEUE = 2'd1;
   localparam logic [1:0] ACT_DELETE  = 2'd2;
   localparam logic [1:0] ACT_LENGTH  = 2'd3;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   localparam int HANDLE_BITS  = 32;
   localparam int COUNT_BITS   = 5;
   localparam int ACTION_BITS  = 2;
   localparam int REQ_TDATA_W  = 32;
   localparam int RSP_TDATA_W  = 40;
   localparam int RSP_PAD_BITS = RSP_TDATA_W - HANDLE_BITS - COUNT_BITS;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

`default_nettype wire

>>> src/fqd_cell.sv
// One queue slot: holds a handle, loads it or takes its right neighbor, compares to a key.
`default_nettype none

module fqd_cell #(
   parameter int W = 32
) (
   input  wire                   clock,
   input  wire fqd_pkg::cell_ctl_type ctl,
   input  wire  [W-1:0]          load_data,
   input  wire  [W-1:0]          right_data,
   input  wire  [W-1:0]          key,
   output logic [W-1:0]          data_out,
   output logic                  match
);

   logic [W-1:0] data_ff;
   logic [W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.load) begin
         data_in = load_data;
      end else if (ctl.shift) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign match    = (data_ff == key);

endmodule

`default_nettype wire

>>> src/fifo_queue_with_delete.sv
// Top level: bounded handle queue built from a row of shifting cells, with delete by value.
// Enqueue, dequeue, length and a null delete are answered at once; the response is registered and
// shows the cycle after the request is taken.
// A non-null delete on a non-empty queue scans one stored entry per cycle; its last step waits for a free response.
// A new request is taken while a response waits only if that response leaves this cycle.
// Synchronous reset clears the count, the controller and the response valid, not the slots.
`default_nettype none

module fifo_queue_with_delete #(
   parameter int DEPTH        = 16,
   parameter int HANDLE_WIDTH = 32
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [fqd_pkg::REQ_TDATA_W-1:0]     req_tdata,   // [31:0] handle_in
   input  wire  [fqd_pkg::ACTION_BITS-1:0]     req_tuser,   // [1:0] action
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [fqd_pkg::RSP_TDATA_W-1:0]     rsp_tdata,   // [31:0] handle_out, [36:32] count_out
   output logic [0:0]                          rsp_tuser    // [0] status
);

   localparam int SW = (HANDLE_WIDTH < fqd_pkg::HANDLE_BITS) ? HANDLE_WIDTH
                                                              : fqd_pkg::HANDLE_BITS;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);

   typedef enum logic {
      ST_IDLE,
      ST_SWEEP
   } state_type;

   state_type                        state_ff, state_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic [IW-1:0]                    ptr_ff, ptr_in;
   logic                             found_ff, found_in;
   logic [SW-1:0]                    key_ff, key_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_status_ff, rsp_status_in;
   logic [fqd_pkg::HANDLE_BITS-1:0]  rsp_handle_ff, rsp_handle_in;
   logic [fqd_pkg::COUNT_BITS-1:0]   rsp_count_ff, rsp_count_in;

   fqd_pkg::cell_ctl_type            ctl [DEPTH];
   logic [SW-1:0]                    cell_data [DEPTH];
   logic [DEPTH-1:0]                 match;

   logic [SW-1:0]                    handle;
   logic                             out_free;
   logic                             req_fire;
   logic                             hit;
   logic                             last;

   assign handle   = req_tdata[SW-1:0];
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire = req_tvalid && req_tready;
   assign hit      = found_ff || match[ptr_ff];
   assign last     = (CW'(ptr_ff) + CW'(1)) == count_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      found_in      = found_ff;
      key_in        = key_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_count_in  = rsp_count_ff;
      for (int i = 0; i < DEPTH; i++) begin
         ctl[i] = '0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_status_in = fqd_pkg::STATUS_OK;
               rsp_handle_in = '0;
               unique case (req_tuser)
                  fqd_pkg::ACT_ENQUEUE: begin
                     rsp_valid_in = 1'b1;
                     if (handle == '0 || count_ff == CW'(DEPTH)) begin
                        rsp_status_in = fqd_pkg::STATUS_ERROR;
                     end else begin
                        for (int i = 0; i < DEPTH; i++) begin
                           ctl[i].load = (count_ff == CW'(i));
                        end
                        count_in = count_ff + CW'(1);
                     end
                  end
                  fqd_pkg::ACT_DEQUEUE: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == '0) begin
                        rsp_status_in = fqd_pkg::STATUS_ERROR;
                     end else begin
                        for (int i = 0; i < DEPTH; i++) begin
                           ctl[i].shift = 1'b1;
                        end
                        rsp_handle_in = fqd_pkg::HANDLE_BITS'(cell_data[0]);
                        count_in      = count_ff - CW'(1);
                     end
                  end
                  fqd_pkg::ACT_DELETE: begin
                     if (handle == '0 || count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = fqd_pkg::STATUS_ERROR;
                     end else begin
                        key_in   = handle;
                        ptr_in   = '0;
                        found_in = 1'b0;
                        state_in = ST_SWEEP;
                     end
                  end
                  fqd_pkg::ACT_LENGTH: begin
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
               rsp_count_in = fqd_pkg::COUNT_BITS'(count_in);
            end
         end
         ST_SWEEP: begin
            if (!last || out_free) begin
               for (int i = 0; i < DEPTH; i++) begin
                  ctl[i].shift = hit && (ptr_ff == IW'(i));
               end
               found_in = hit;
               ptr_in   = IW'(ptr_ff + 1'b1);
               if (last) begin
                  count_in      = hit ? count_ff - CW'(1) : count_ff;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = hit ? fqd_pkg::STATUS_OK : fqd_pkg::STATUS_ERROR;
                  rsp_handle_in = '0;
                  rsp_count_in  = fqd_pkg::COUNT_BITS'(count_in);
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         ptr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         ptr_ff       <= ptr_in;
      end
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_count_ff  <= rsp_count_in;
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [SW-1:0] right;
      if (g == DEPTH - 1) begin : g_tail
         assign right = '0;
      end else begin : g_body
         assign right = cell_data[g+1];
      end
      fqd_cell #(
         .W (SW)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl[g]),
         .load_data  (handle),
         .right_data (right),
         .key        (key_ff),
         .data_out   (cell_data[g]),
         .match      (match[g])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{fqd_pkg::RSP_PAD_BITS{1'b0}}, rsp_count_ff, rsp_handle_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

>>> src/fqd_checker.sv
// Port-level checks for the handle queue, bound to the top level.
`default_nettype none

module fqd_checker #(
   parameter int DEPTH = 16
) (
   input wire                               clock,
   input wire                               reset,
   input wire                               req_tvalid,
   input wire                               req_tready,
   input wire [fqd_pkg::ACTION_BITS-1:0]    req_tuser,
   input wire                               rsp_tvalid,
   input wire                               rsp_tready,
   input wire [fqd_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input wire [0:0]                         rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_error_null: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[fqd_pkg::HANDLE_BITS-1:0] == '0)
      else $error("error response carries a handle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (DEPTH < 32) |->
         rsp_tdata[fqd_pkg::HANDLE_BITS +: fqd_pkg::COUNT_BITS] <= fqd_pkg::COUNT_BITS'(DEPTH))
      else $error("count exceeds depth");

   a_len_ok: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == fqd_pkg::ACT_LENGTH |=>
         rsp_tvalid && !rsp_tuser[0])
      else $error("length query did not succeed");

endmodule

bind fifo_queue_with_delete fqd_checker #(
   .DEPTH (DEPTH)
) u_fqd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the handle queue with enqueue, dequeue, delete by value and length.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH = 16;
   localparam int PHASE_ITEMS = 450;

   typedef struct packed {
      logic                            status;
      logic [fqd_pkg::HANDLE_BITS-1:0] handle;
      logic [fqd_pkg::COUNT_BITS-1:0]  count;
   } queue_response_type;

   logic                              clock;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [fqd_pkg::REQ_TDATA_W-1:0]   req_tdata  = '0;
   logic [fqd_pkg::ACTION_BITS-1:0]   req_tuser  = fqd_pkg::ACT_LENGTH;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [fqd_pkg::RSP_TDATA_W-1:0]   rsp_tdata;
   logic [0:0]                        rsp_tuser;

   logic [fqd_pkg::HANDLE_BITS-1:0]   stored_handles[$];
   queue_response_type                pending_responses[$];
   logic [fqd_pkg::HANDLE_BITS-1:0]   handle_pool[8];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int responses_checked = 0;
   int error_responses = 0;
   int peak_depth = 0;
   int action_count[4] = '{0, 0, 0, 0};

   fifo_queue_with_delete #(
      .DEPTH       (QUEUE_DEPTH),
      .HANDLE_WIDTH(fqd_pkg::HANDLE_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("TB_ERROR");
      $finish;
   end

   function automatic queue_response_type predict_queue_response(
         input logic [1:0] action,
         input logic [fqd_pkg::HANDLE_BITS-1:0] handle);
      queue_response_type rsp;
      int hit;
      rsp = '{status: fqd_pkg::STATUS_OK, handle: '0, count: '0};
      hit = -1;
      case (action)
         fqd_pkg::ACT_ENQUEUE: begin
            if (handle == '0 || stored_handles.size() >= QUEUE_DEPTH) begin
               rsp.status = fqd_pkg::STATUS_ERROR;
            end else begin
               stored_handles.push_back(handle);
            end
         end
         fqd_pkg::ACT_DEQUEUE: begin
            if (stored_handles.size() == 0) begin
               rsp.status = fqd_pkg::STATUS_ERROR;
            end else begin
               rsp.handle = stored_handles.pop_front();
            end
         end
         fqd_pkg::ACT_DELETE: begin
            if (handle != '0) begin
               for (int i = 0; i < stored_handles.size(); i++) begin
                  if (hit < 0 && stored_handles[i] == handle) begin
                     hit = i;
                  end
               end
            end
            if (hit < 0) begin
               rsp.status = fqd_pkg::STATUS_ERROR;
            end else begin
               stored_handles.delete(hit);
            end
         end
         default: begin
         end
      endcase
      rsp.count = fqd_pkg::COUNT_BITS'(stored_handles.size());
      if (rsp.status == fqd_pkg::STATUS_ERROR) begin
         error_responses++;
      end
      if (stored_handles.size() > peak_depth) begin
         peak_depth = stored_handles.size();
      end
      return rsp;
   endfunction

   task automatic send_request(input logic [1:0] action,
                               input logic [fqd_pkg::HANDLE_BITS-1:0] handle);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         req_tuser  <= fqd_pkg::ACTION_BITS'($urandom);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= handle;
      req_tuser  <= action;
      do @(posedge clock); while (!req_tready);
      action_count[action]++;
      pending_responses.push_back(predict_queue_response(action, handle));
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : check_responses
      queue_response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_responses.size() == 0) begin
            $error("unexpected response: status %0d handle_out %h count_out %0d",
                   rsp_tuser[0], rsp_tdata[fqd_pkg::HANDLE_BITS-1:0],
                   rsp_tdata[fqd_pkg::HANDLE_BITS +: fqd_pkg::COUNT_BITS]);
            error_count++;
         end else begin
            want = pending_responses.pop_front();
            responses_checked++;
            if (rsp_tuser[0] !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tdata[fqd_pkg::HANDLE_BITS-1:0] !== want.handle) begin
               $error("handle_out: expected %h, got %h", want.handle,
                      rsp_tdata[fqd_pkg::HANDLE_BITS-1:0]);
               error_count++;
            end
            if (rsp_tdata[fqd_pkg::HANDLE_BITS +: fqd_pkg::COUNT_BITS] !== want.count) begin
               $error("count_out: expected %0d, got %0d", want.count,
                      rsp_tdata[fqd_pkg::HANDLE_BITS +: fqd_pkg::COUNT_BITS]);
               error_count++;
            end
            if (rsp_tdata[fqd_pkg::RSP_TDATA_W-1:fqd_pkg::HANDLE_BITS+fqd_pkg::COUNT_BITS]
                !== '0) begin
               $error("rsp_tdata pad: expected 0, got %h",
                      rsp_tdata[fqd_pkg::RSP_TDATA_W-1:fqd_pkg::HANDLE_BITS+fqd_pkg::COUNT_BITS]);
               error_count++;
            end
         end
      end
   end

   task automatic test_empty_queue();
      send_request(fqd_pkg::ACT_DEQUEUE, 32'h0);
      send_request(fqd_pkg::ACT_DELETE, 32'h0);
      send_request(fqd_pkg::ACT_DELETE, 32'hFFFF_FFFF);
      send_request(fqd_pkg::ACT_LENGTH, 32'hFFFF_FFFF);
      send_request(fqd_pkg::ACT_ENQUEUE, 32'h0);
   endtask

   task automatic test_fill_to_full();
      send_request(fqd_pkg::ACT_ENQUEUE, 32'hFFFF_FFFF);
      send_request(fqd_pkg::ACT_ENQUEUE, 32'h0000_0001);
      send_request(fqd_pkg::ACT_ENQUEUE, 32'h0000_0007);
      send_request(fqd_pkg::ACT_ENQUEUE, 32'h8000_0000);
      send_request(fqd_pkg::ACT_ENQUEUE, 32'h0000_0007);
      for (int i = 5; i < QUEUE_DEPTH; i++) begin
         send_request(fqd_pkg::ACT_ENQUEUE, $urandom | 32'h1);
      end
      send_request(fqd_pkg::ACT_ENQUEUE, 32'h5A5A_5A5A);
   endtask

   task automatic test_delete_cases();
      send_request(fqd_pkg::ACT_DELETE, 32'h0000_0007);
      send_request(fqd_pkg::ACT_DELETE, 32'h0000_0002);
      send_request(fqd_pkg::ACT_DEQUEUE, 32'h0);
      send_request(fqd_pkg::ACT_LENGTH, 32'h0);
   endtask

   function automatic logic [fqd_pkg::HANDLE_BITS-1:0] pick_handle();
      int roll;
      roll = $urandom_range(99);
      if (roll < 6) begin
         return '0;
      end else if (roll < 55) begin
         return handle_pool[$urandom_range(7)];
      end
      return $urandom;
   endfunction

   task automatic test_random_traffic(input int items);
      int mode;
      int roll;
      logic [1:0] action;
      logic [fqd_pkg::HANDLE_BITS-1:0] handle;
      mode = 0;
      for (int n = 0; n < items; n++) begin
         if (n % 32 == 0) begin
            mode = $urandom_range(2);
         end
         roll = $urandom_range(99);
         case (mode)
            0: action = (roll < 60) ? fqd_pkg::ACT_ENQUEUE :
                        (roll < 75) ? fqd_pkg::ACT_DEQUEUE :
                        (roll < 95) ? fqd_pkg::ACT_DELETE : fqd_pkg::ACT_LENGTH;
            1: action = (roll < 20) ? fqd_pkg::ACT_ENQUEUE :
                        (roll < 65) ? fqd_pkg::ACT_DEQUEUE :
                        (roll < 95) ? fqd_pkg::ACT_DELETE : fqd_pkg::ACT_LENGTH;
            default: action = (roll < 35) ? fqd_pkg::ACT_ENQUEUE :
                              (roll < 60) ? fqd_pkg::ACT_DEQUEUE :
                              (roll < 90) ? fqd_pkg::ACT_DELETE : fqd_pkg::ACT_LENGTH;
         endcase
         handle = pick_handle();
         if (action == fqd_pkg::ACT_DELETE && stored_handles.size() > 0 &&
             $urandom_range(99) < 65) begin
            handle = stored_handles[$urandom_range(stored_handles.size() - 1)];
         end
         send_request(action, handle);
      end
   endtask

   initial begin : run_tests
      handle_pool[0] = 32'hFFFF_FFFF;
      handle_pool[1] = 32'h0000_0001;
      handle_pool[2] = 32'h8000_0000;
      for (int i = 3; i < 8; i++) begin
         handle_pool[i] = $urandom;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 27;
      recv_idle_pct = 58;
      test_empty_queue();
      test_fill_to_full();
      test_delete_cases();
      test_random_traffic(PHASE_ITEMS);

      send_idle_pct = 58;
      recv_idle_pct = 27;
      test_random_traffic(PHASE_ITEMS);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(PHASE_ITEMS);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_responses.size() != 0) begin
         @(posedge clock);
      end
      repeat (QUEUE_DEPTH + 8) @(posedge clock);

      $display("Covered %0d requests: %0d enqueue, %0d dequeue, %0d delete, %0d length.",
               action_count[0] + action_count[1] + action_count[2] + action_count[3],
               action_count[fqd_pkg::ACT_ENQUEUE], action_count[fqd_pkg::ACT_DEQUEUE],
               action_count[fqd_pkg::ACT_DELETE], action_count[fqd_pkg::ACT_LENGTH]);
      $display("Checked %0d responses, %0d of them errors; queue depth peaked at %0d.",
               responses_checked, error_responses, peak_depth);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
src/fqd_pkg.sv
src/fqd_cell.sv
src/fifo_queue_with_delete.sv
src/fqd_checker.sv
tb/testbench.sv
